/* src/rau_pkg.sv */
// ----------------------------------------------------------------------------
// rau_pkg: shared types and constants for the rational arithmetic unit
// Operation codes, status codes and the sequencer state type.
// ----------------------------------------------------------------------------
package rau_pkg;

   typedef enum logic [1:0] {
      MODE_ADD = 2'd0,
      MODE_SUB = 2'd1,
      MODE_MUL = 2'd2,
      MODE_DIV = 2'd3
   } mode_type;

   localparam logic STATUS_OK      = 1'b0;
   localparam logic STATUS_ZERODEN = 1'b1;

   typedef enum logic [9:0] {
      ST_IDLE  = 10'b0000000001,
      ST_MUL1  = 10'b0000000010,
      ST_MUL2  = 10'b0000000100,
      ST_MUL3  = 10'b0000001000,
      ST_COMB  = 10'b0000010000,
      ST_GCD   = 10'b0000100000,
      ST_DIVN  = 10'b0001000000,
      ST_DIVD  = 10'b0010000000,
      ST_DONE  = 10'b0100000000,
      ST_OUT   = 10'b1000000000
   } state_type;

endpackage

/* src/rau_if.sv */
// ----------------------------------------------------------------------------
// rau_req_if / rau_rsp_if: valid/ready channels of the rational unit
// Request carries operands and mode, response the reduced fraction.
// ----------------------------------------------------------------------------
interface rau_req_if #(parameter int OW = 32);
   logic          valid;
   logic          ready;
   logic [1:0]    mode;
   logic [OW-1:0] x_num;
   logic [OW-1:0] x_den;
   logic [OW-1:0] y_num;
   logic [OW-1:0] y_den;
   modport source (output valid, mode, x_num, x_den, y_num, y_den, input ready);
   modport sink   (input valid, mode, x_num, x_den, y_num, y_den, output ready);
endinterface

interface rau_rsp_if;
   logic        valid;
   logic        ready;
   logic [63:0] res_num;
   logic [62:0] res_den;
   logic        status;
   modport source (output valid, res_num, res_den, status, input ready);
   modport sink   (input valid, res_num, res_den, status, output ready);
endinterface

/* src/rational_arithmetic_unit.sv */
// ----------------------------------------------------------------------------
// rational_arithmetic_unit: add, subtract, multiply or divide two fractions
// Result is reduced to lowest terms with a positive denominator.
// ----------------------------------------------------------------------------
// Usage:
//   req channel: mode and two signed fractions x_num/x_den, y_num/y_den.
//   rsp channel: res_num (signed), res_den (positive), status (1 when an
//   input denominator is zero, result 0/1).
//   One word at a time: req_ready is high only while the unit is idle.
//   Sequence: product states MUL1 and MUL2 (and MUL3 for add/subtract),
//   the combine state, then the Euclidean gcd with one restoring
//   remainder step per cycle, a quotient pass for the numerator and one
//   for the denominator, and the DONE state that loads the output
//   register. A zero denominator or zero numerator skips the gcd. The
//   number of gcd remainders depends on the data, from 1 up to about 92;
//   the unit is ready again in the cycle after the result handshake.
//   The gcd and both quotient passes go through one shared 64-bit subtract/compare divider.
//   A result is held in the output register until rsp_ready; the unit does
//   not take a new word meanwhile. Synchronous reset returns to idle with
//   no result pending.
// ----------------------------------------------------------------------------
module rational_arithmetic_unit
   import rau_pkg::*;
#(
   parameter int OPERAND_WIDTH = 32
) (
   input  logic      clock,
   input  logic      reset,
   rau_req_if.sink   req,
   rau_rsp_if.source rsp
);

   localparam int OW = OPERAND_WIDTH;

   state_type   state_ff, state_in;
   logic [63:0] a_ff, a_in;        // gcd p / dividend
   logic [63:0] b_ff, b_in;        // gcd q / divisor
   logic [63:0] num_ff, num_in;
   logic [63:0] den_ff, den_in;
   logic [63:0] t1_ff, t1_in;
   logic [63:0] t2_ff, t2_in;
   logic [63:0] rem_ff, rem_in;
   logic [63:0] quo_ff, quo_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        neg_ff, neg_in;
   logic        sx_ff, sx_in, sy_ff, sy_in;
   logic        zd_ff, zd_in;
   logic [1:0]  mode_ff, mode_in;
   logic [OW-1:0] xn_ff, xd_ff, yn_ff, yd_ff;
   logic [OW-1:0] xn_in, xd_in, yn_in, yd_in;
   logic [63:0] onum_ff, onum_in;
   logic [62:0] oden_ff, oden_in;
   logic        ost_ff, ost_in;

   // magnitude of an operand
   function automatic logic [OW-1:0] mag(input logic [OW-1:0] v);
      mag = v[OW-1] ? (~v + 1'b1) : v;
   endfunction

   // shared multiplier operands, one product per cycle
   logic [OW-1:0] ma, mb;
   logic [63:0]   prod;
   assign prod = 64'(ma) * 64'(mb);

   // shared restoring divider step
   logic [64:0] shifted;
   logic [64:0] diff;
   assign shifted = {rem_ff, a_ff[63]};
   assign diff    = shifted - {1'b0, b_ff};

   assign req.ready = (state_ff == ST_IDLE);
   assign rsp.valid = (state_ff == ST_OUT);
   assign rsp.res_num = onum_ff;
   assign rsp.res_den = oden_ff;
   assign rsp.status  = ost_ff;

   always_comb begin
      ma = xn_ff;
      mb = yd_ff;
      case (state_ff)
         ST_MUL1: begin
            ma = xn_ff;
            mb = (mode_ff == MODE_MUL) ? yn_ff : yd_ff;
         end
         ST_MUL2: begin
            ma = (mode_ff == MODE_MUL || mode_ff == MODE_DIV) ? xd_ff : yn_ff;
            mb = (mode_ff == MODE_MUL) ? yd_ff : (mode_ff == MODE_DIV) ? yn_ff : xd_ff;
         end
         ST_MUL3: begin
            ma = xd_ff;
            mb = yd_ff;
         end
         default: begin
            ma = xn_ff;
            mb = yd_ff;
         end
      endcase
   end

   // sequencer
   always_comb begin
      logic s2;
      state_in = state_ff;
      a_in = a_ff;     b_in = b_ff;
      num_in = num_ff; den_in = den_ff;
      t1_in = t1_ff;   t2_in = t2_ff;
      rem_in = rem_ff; quo_in = quo_ff;
      cnt_in = cnt_ff; neg_in = neg_ff;
      sx_in = sx_ff;   sy_in = sy_ff;
      zd_in = zd_ff;   mode_in = mode_ff;
      xn_in = xn_ff;   xd_in = xd_ff;
      yn_in = yn_ff;   yd_in = yd_ff;
      onum_in = onum_ff; oden_in = oden_ff; ost_in = ost_ff;
      s2 = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req.valid) begin
               mode_in = req.mode;
               xn_in = mag(req.x_num); xd_in = mag(req.x_den);
               yn_in = mag(req.y_num); yd_in = mag(req.y_den);
               sx_in = req.x_num[OW-1] ^ req.x_den[OW-1];
               sy_in = req.y_num[OW-1] ^ req.y_den[OW-1];
               zd_in = (req.x_den == '0) || (req.y_den == '0);
               state_in = ST_MUL1;
            end
         end
         ST_MUL1: begin
            t1_in = prod;
            state_in = ST_MUL2;
         end
         ST_MUL2: begin
            t2_in = prod;
            state_in = (mode_ff == MODE_MUL || mode_ff == MODE_DIV) ? ST_COMB : ST_MUL3;
            den_in = prod;
         end
         ST_MUL3: begin
            den_in = prod;
            state_in = ST_COMB;
         end
         ST_COMB: begin
            // combine products into magnitude and sign
            if (mode_ff == MODE_MUL || mode_ff == MODE_DIV) begin
               num_in = t1_ff;
               neg_in = sx_ff ^ sy_ff;
            end else begin
               s2 = (mode_ff == MODE_SUB) ? ~sy_ff : sy_ff;
               if (sx_ff == s2) begin
                  num_in = t1_ff + t2_ff;
                  neg_in = sx_ff;
               end else if (t1_ff >= t2_ff) begin
                  num_in = t1_ff - t2_ff;
                  neg_in = sx_ff;
               end else begin
                  num_in = t2_ff - t1_ff;
                  neg_in = s2;
               end
            end
            if (zd_ff || num_in == '0 || den_ff == '0) begin
               onum_in = '0;
               oden_in = 63'd1;
               ost_in = zd_ff ? STATUS_ZERODEN : STATUS_OK;
               state_in = ST_OUT;
            end else begin
               a_in = num_in; b_in = den_ff;
               rem_in = '0; cnt_in = '0;
               state_in = ST_GCD;
            end
         end
         ST_GCD, ST_DIVN, ST_DIVD: begin
            // one restoring step: quotient bit into a, remainder in rem
            if (!diff[64]) begin
               rem_in = diff[63:0];
               a_in = {a_ff[62:0], 1'b1};
            end else begin
               rem_in = shifted[63:0];
               a_in = {a_ff[62:0], 1'b0};
            end
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'd63) begin
               cnt_in = '0;
               if (state_ff == ST_GCD) begin
                  // p <- q, q <- r; stop when r is zero
                  if (rem_in == '0) begin
                     quo_in = b_ff;       // gcd
                     a_in = num_ff; b_in = b_ff; rem_in = '0;
                     state_in = ST_DIVN;
                  end else begin
                     a_in = b_ff; b_in = rem_in; rem_in = '0;
                  end
               end else if (state_ff == ST_DIVN) begin
                  num_in = a_in;
                  a_in = den_ff; b_in = quo_ff; rem_in = '0;
                  state_in = ST_DIVD;
               end else begin
                  den_in = a_in;
                  state_in = ST_DONE;
               end
            end
         end
         ST_DONE: begin
            onum_in = neg_ff ? (64'd0 - num_ff) : num_ff;
            oden_in = den_ff[62:0];
            ost_in = STATUS_OK;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (rsp.ready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      a_ff <= a_in;     b_ff <= b_in;
      num_ff <= num_in; den_ff <= den_in;
      t1_ff <= t1_in;   t2_ff <= t2_in;
      rem_ff <= rem_in; quo_ff <= quo_in;
      cnt_ff <= cnt_in; neg_ff <= neg_in;
      sx_ff <= sx_in;   sy_ff <= sy_in;
      zd_ff <= zd_in;   mode_ff <= mode_in;
      xn_ff <= xn_in;   xd_ff <= xd_in;
      yn_ff <= yn_in;   yd_ff <= yd_in;
      onum_ff <= onum_in; oden_ff <= oden_in; ost_ff <= ost_in;
   end

`ifndef SYNTHESIS
   // a response always has a nonzero denominator
   a_den: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> rsp.res_den != '0)
      else $error("zero result denominator");
   // flagged results are forced to 0/1
   a_flag: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && rsp.status == STATUS_ZERODEN) |->
         (rsp.res_num == '0 && rsp.res_den == 63'd1))
      else $error("flagged result not 0/1");
   // a stalled response holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && !rsp.ready) |=> (rsp.valid && $stable(rsp.res_num)))
      else $error("response dropped under stall");
   // never ready while a result is pending
   a_busy: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> !req.ready)
      else $error("ready with result pending");
`endif

endmodule

/* test/rational_arithmetic_unit_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rational_arithmetic_unit_tb: self-checking bench for the fraction unit
// Drives fraction pairs in all four modes through the request channel,
// predicts each reduced result and compares it with the response word.
// ----------------------------------------------------------------------------
module rational_arithmetic_unit_tb
   import rau_pkg::*;
;

   localparam int OW        = 32;
   localparam int MAX_CYCLE = 40000000;

   typedef struct {
      mode_type         mode;
      logic [OW-1:0]    x_num;
      logic [OW-1:0]    x_den;
      logic [OW-1:0]    y_num;
      logic [OW-1:0]    y_den;
   } operand_word_type;

   typedef struct {
      logic [63:0] num;
      logic [62:0] den;
      logic        status;
   } fraction_word_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   rau_req_if #(.OW(OW)) req ();
   rau_rsp_if            rsp ();

   rational_arithmetic_unit #(.OPERAND_WIDTH(OW)) dut (
      .clock(clock), .reset(reset), .req(req), .rsp(rsp)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   operand_word_type  pending_q[$];
   fraction_word_type reduced_q[$];
   int           error_count = 0;
   int           checked_count = 0;
   int           zero_den_count = 0;
   int           cycle_count = 0;
   bit           stim_done = 1'b0;
   bit           req_fire = 1'b0;

   task automatic report_mismatch(input string msg);
      $display("mismatch @%0d: %s", cycle_count, msg);
      error_count++;
   endtask

   // magnitude of a signed operand, sign returned separately
   function automatic logic [63:0] magnitude(input logic [OW-1:0] v, output bit neg);
      neg = v[OW-1];
      return neg ? 64'((~v) + 1'b1) & ((64'd1 << OW) - 1) : 64'(v);
   endfunction

   function automatic fraction_word_type reduce_fraction(input operand_word_type w);
      fraction_word_type r;
      bit snx, sdx, sny, sdy, sx, sy, s1, s2, neg;
      logic [63:0] xn, xd, yn, yd, t1, t2, num, den, p, q, t;
      xn = magnitude(w.x_num, snx);
      xd = magnitude(w.x_den, sdx);
      yn = magnitude(w.y_num, sny);
      yd = magnitude(w.y_den, sdy);
      sx = snx ^ sdx;
      sy = sny ^ sdy;
      r.num = 64'd0; r.den = 63'd1; r.status = STATUS_OK;
      if (xd == 0 || yd == 0) begin
         r.status = STATUS_ZERODEN;
         return r;
      end
      neg = 1'b0;
      case (w.mode)
         MODE_ADD, MODE_SUB: begin
            t1 = xn * yd;
            t2 = yn * xd;
            s1 = sx;
            s2 = (w.mode == MODE_SUB) ? !sy : sy;
            if (s1 == s2) begin
               num = t1 + t2; neg = s1;
            end else if (t1 >= t2) begin
               num = t1 - t2; neg = s1;
            end else begin
               num = t2 - t1; neg = s2;
            end
            den = xd * yd;
         end
         MODE_MUL: begin
            num = xn * yn; den = xd * yd; neg = sx ^ sy;
         end
         default: begin
            num = xn * yd; den = xd * yn; neg = sx ^ sy;
         end
      endcase
      if (num == 0 || den == 0) return r;
      // Euclid on the magnitudes
      p = num; q = den;
      while (q != 0) begin
         t = p % q; p = q; q = t;
      end
      num = num / p;
      den = den / p;
      r.num = neg ? (64'd0 - num) : num;
      r.den = den[62:0];
      return r;
   endfunction

   // biased operand: edges, small values or full random
   function automatic logic [OW-1:0] pick_operand();
      case ($urandom_range(9))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return 32'hFFFF_FFFF;
         3: return 32'd0;
         4, 5: return 32'($signed($urandom_range(40)) - 20);
         6: return 32'($signed($urandom_range(2000)) - 1000);
         default: return $urandom;
      endcase
   endfunction

   function automatic int gap_length();
      int k;
      k = $urandom_range(99);
      if (k < 50) return 0;
      if (k < 92) return $urandom_range(3, 1);
      return $urandom_range(60, 10);
   endfunction

   task automatic push_word(input mode_type m, input logic [OW-1:0] a, b, c, d);
      operand_word_type w;
      w.mode = m; w.x_num = a; w.x_den = b; w.y_num = c; w.y_den = d;
      pending_q.push_back(w);
   endtask

   // stimulus: directed corners then random words
   initial begin
      mode_type m;
      logic [OW-1:0] mx, mn;
      mx = 32'h7FFF_FFFF; mn = 32'h8000_0000;
      for (int i = 0; i < 4; i++) begin
         m = mode_type'(i);
         push_word(m, mx, mn, mn, mx);
         push_word(m, mn, 32'hFFFF_FFFF, mn, 32'hFFFF_FFFF);
         push_word(m, 0, 5, 3, -7);
         push_word(m, 6, -4, 0, 9);
         push_word(m, 3, 0, 1, 2);
      end
      push_word(MODE_DIV, 1, 2, 0, 3);
      push_word(MODE_SUB, 2, 4, -3, -6);
      push_word(MODE_ADD, 1, 3, -1, 3);
      push_word(MODE_DIV, mn, mn, mx, mx);
      push_word(MODE_MUL, 1, 1, 1, 0);
      for (int i = 0; i < 1500; i++)
         push_word(mode_type'($urandom_range(3)), pick_operand(), pick_operand(),
                   pick_operand(), pick_operand());
      stim_done = 1'b1;
   end

   // request handshake seen at the last rising edge
   always @(posedge clock) begin
      req_fire <= req.valid && req.ready;
   end

   // driver: present words at the falling edge
   int send_gap = 0;

   always @(negedge clock) begin
      if (reset) begin
         req.valid <= 1'b0;
         req.mode  <= '0;
         req.x_num <= '0; req.x_den <= '0;
         req.y_num <= '0; req.y_den <= '0;
      end else if (req.valid && !req_fire) begin
         // hold until accepted
      end else if (send_gap > 0) begin
         req.valid <= 1'b0;
         send_gap  <= send_gap - 1;
      end else if (pending_q.size() > 0) begin
         operand_word_type w;
         w = pending_q.pop_front();
         req.valid <= 1'b1;
         req.mode  <= w.mode;
         req.x_num <= w.x_num; req.x_den <= w.x_den;
         req.y_num <= w.y_num; req.y_den <= w.y_den;
         reduced_q.push_back(reduce_fraction(w));
         send_gap <= gap_length();
      end else begin
         req.valid <= 1'b0;
      end
   end

   // response stalls
   int stall = 0;
   always @(negedge clock) begin
      if (stall > 0) begin
         rsp.ready <= 1'b0;
         stall <= stall - 1;
      end else begin
         rsp.ready <= 1'b1;
         stall <= gap_length();
      end
   end

   // monitor: compare each accepted result word
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (!reset && rsp.valid && rsp.ready) begin
         if (reduced_q.size() == 0) begin
            report_mismatch("result word with none expected");
         end else begin
            fraction_word_type e;
            e = reduced_q.pop_front();
            checked_count++;
            if (e.status == STATUS_ZERODEN) zero_den_count++;
            if (rsp.res_num !== e.num)
               report_mismatch($sformatf("res_num %0d exp %0d",
                  $signed(rsp.res_num), $signed(e.num)));
            if (rsp.res_den !== e.den)
               report_mismatch($sformatf("res_den %0d exp %0d", rsp.res_den, e.den));
            if (rsp.status !== e.status)
               report_mismatch($sformatf("status %0b exp %0b", rsp.status, e.status));
         end
      end
   end

   // run control
   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      wait (stim_done && pending_q.size() == 0 && !req.valid && reduced_q.size() == 0);
      repeat (50) @(posedge clock);
      $display("checked %0d result words over all four modes, %0d with zero denominator",
               checked_count, zero_den_count);
      if (error_count == 0 && reduced_q.size() == 0)
         $display("PASS rational_arithmetic_unit");
      else
         $display("FAIL rational_arithmetic_unit");
      $finish;
   end

   always @(posedge clock) begin
      if (cycle_count >= MAX_CYCLE) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("FAIL rational_arithmetic_unit");
         $finish;
      end
   end

endmodule
